### sv/cba_pkg.sv
// Package for the channel bitmap allocator: word types, status and operation codes,
// and the sizing of the in-use bitmap memory.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cba_pkg;

    localparam int NUM_CHANNELS = 99;
    localparam int CHAN_W       = 8;
    localparam int WORD_W       = 16;
    localparam int NUM_WORDS    = (NUM_CHANNELS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int COL_W        = $clog2(WORD_W);
    localparam int IDX_W        = ADDR_W + COL_W;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                     operation;
        logic signed [CHAN_W-1:0] channel;
    } in_word_t;

    typedef struct packed {
        logic signed [CHAN_W-1:0] granted_channel;
        logic [1:0]               status;
    } out_word_t;

endpackage

`default_nettype wire

### sv/cba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### sv/channel_bitmap_allocator_top.sv
// Channel bitmap allocator top level: request decode, bitmap read-modify-write, search.
// Depends on cba_pkg and cba_ram.
`timescale 1ns / 1ps
`default_nettype none

// Allocates and frees channels 1 to 99 from an in-use bitmap kept in a small RAM of
// 16-bit rows, one row read per cycle. A free, a forced allocate or a preferred allocate
// whose channel is free passes through the check state to the result state; a range
// error or an ignored free goes straight to the result state. A search reads the rows
// from the top channel downward, one row per cycle, and follows the check state when a
// preferred channel was tried first. One request is worked on at a time; a new request is
// taken as soon as the previous result sits in the output register.
module channel_bitmap_allocator_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire cba_pkg::in_word_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output cba_pkg::out_word_t     rsp
);

    localparam int CW = cba_pkg::CHAN_W;
    localparam int WW = cba_pkg::WORD_W;
    localparam int AW = cba_pkg::ADDR_W;
    localparam int XW = cba_pkg::IDX_W;
    localparam int LW = cba_pkg::COL_W;
    localparam logic [AW-1:0] TOP_ROW = AW'(cba_pkg::NUM_WORDS - 1);
    localparam logic [CW-1:0] MAX_CHAN = CW'(cba_pkg::NUM_CHANNELS);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CHECK  = 4'b0010,
        S_SCAN   = 4'b0100,
        S_RESULT = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           rd_row_reg;
    logic [cba_pkg::NUM_WORDS-1:0] row_valid_reg;
    logic                    out_valid_reg;
    cba_pkg::out_word_t      out_data_reg;
    cba_pkg::out_word_t      res_reg, res_next;
    logic                    op_reg, op_next;
    logic                    neg_reg, neg_next;
    logic [CW-1:0]           mag_reg, mag_next;

    logic [AW-1:0]           rd_addr;
    logic [WW-1:0]           rd_data;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [WW-1:0]           wr_data;

    logic                    accept;
    logic [CW-1:0]           ch_u;
    logic [CW-1:0]           mag_in;
    logic [CW-1:0]           mag_in_m1;
    logic [CW-1:0]           mag_reg_m1;
    logic                    in_range;
    logic [XW-1:0]           idx_reg;
    logic [WW-1:0]           cur_word;
    logic [WW-1:0]           bit_mask;
    logic [WW-1:0]           avail;
    logic                    found;
    logic [LW-1:0]           hi_pos;
    logic [XW-1:0]           lane_idx;
    logic                    load_out;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    assign ch_u       = req.channel;
    assign mag_in     = ch_u[CW-1] ? (~ch_u + CW'(1)) : ch_u;
    assign mag_in_m1  = mag_in - CW'(1);
    assign in_range   = (mag_in != '0) && (mag_in <= MAX_CHAN);
    assign mag_reg_m1 = mag_reg - CW'(1);
    assign idx_reg    = mag_reg_m1[XW-1:0];

    assign cur_word = row_valid_reg[rd_row_reg] ? rd_data : '0;
    assign bit_mask = WW'(1) << idx_reg[LW-1:0];

    always_comb
    begin
        avail    = '0;
        found    = 1'b0;
        hi_pos   = '0;
        lane_idx = '0;
        for (int c = 0; c < WW; c++)
        begin
            lane_idx = {rd_row_reg, LW'(c)};
            avail[c] = !cur_word[c] && (CW'(lane_idx) < MAX_CHAN);
            if (avail[c])
            begin
                found  = 1'b1;
                hi_pos = LW'(c);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        op_next    = op_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        rd_addr    = rd_row_reg - AW'(1);
        wr_en      = 1'b0;
        wr_addr    = rd_row_reg;
        wr_data    = cur_word;
        load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = mag_in_m1[XW-1:LW];
                if (accept)
                begin
                    op_next  = req.operation;
                    neg_next = ch_u[CW-1];
                    mag_next = mag_in;
                    if (req.operation == cba_pkg::OP_FREE)
                    begin
                        if (!ch_u[CW-1] && in_range)
                        begin
                            state_next = S_CHECK;
                        end
                        else
                        begin
                            res_next   = '{granted_channel: req.channel,
                                           status: cba_pkg::ST_OK};
                            state_next = S_RESULT;
                        end
                    end
                    else if (mag_in > MAX_CHAN)
                    begin
                        res_next   = '{granted_channel: '0, status: cba_pkg::ST_RANGE};
                        state_next = S_RESULT;
                    end
                    else if (mag_in == '0)
                    begin
                        rd_addr    = TOP_ROW;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                rd_addr = TOP_ROW;
                if (op_reg == cba_pkg::OP_FREE)
                begin
                    wr_en      = 1'b1;
                    wr_data    = cur_word & ~bit_mask;
                    res_next   = '{granted_channel: '0, status: cba_pkg::ST_OK};
                    state_next = S_RESULT;
                end
                else if (!neg_reg || !cur_word[idx_reg[LW-1:0]])
                begin
                    wr_en      = 1'b1;
                    wr_data    = cur_word | bit_mask;
                    res_next   = '{granted_channel: mag_reg, status: cba_pkg::ST_OK};
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (found)
                begin
                    wr_en      = 1'b1;
                    wr_data    = cur_word | (WW'(1) << hi_pos);
                    res_next   = '{granted_channel: CW'({rd_row_reg, hi_pos}) + CW'(1),
                                   status: cba_pkg::ST_OK};
                    state_next = S_RESULT;
                end
                else if (rd_row_reg == '0)
                begin
                    res_next   = '{granted_channel: '0, status: cba_pkg::ST_FULL};
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    cba_ram #(
        .WIDTH (WW),
        .DEPTH (cba_pkg::NUM_WORDS)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_row_reg <= rd_addr;
        res_reg    <= res_next;
        op_reg     <= op_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        if (load_out)
        begin
            out_data_reg <= res_reg;
        end
    end

endmodule

`default_nettype wire

### sv/cba_checker.sv
// Port-level checker for the channel bitmap allocator, bound to the top level.
// Depends on cba_pkg and channel_bitmap_allocator_top.
`timescale 1ns / 1ps
`default_nettype none

module cba_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_ready,
    input wire cba_pkg::in_word_t  req,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire cba_pkg::out_word_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response word changed or dropped while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == cba_pkg::ST_OK || rsp.status == cba_pkg::ST_RANGE
                       || rsp.status == cba_pkg::ST_FULL))
        else $error("undefined status code");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != cba_pkg::ST_OK |-> rsp.granted_channel == '0)
        else $error("error response carries a channel");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous request in flight");

endmodule

bind channel_bitmap_allocator_top cba_checker u_cba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire
